// ===== hw/rtl/srq_pkg.sv =====
// ----------------------------------------------------------------------------
// srq_pkg
// Shared types and constants for the sequence reorder queue.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int HANDLE_W     = 16;
  localparam int SEQ_W        = 32;
  localparam int CNT_W        = 7;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GROW_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW_THRESHOLD = 1'd1;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_STALE  = 2'd2,
    STAT_BEYOND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_TAKE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_slot;
    logic [HANDLE_W-1:0] wr_handle;
    logic                clr_en;
    logic [SLOT_W-1:0]   clr_slot;
  } store_ctl_t;

endpackage

// ===== hw/rtl/srq_slot_store.sv =====
// ----------------------------------------------------------------------------
// srq_slot_store
// Window slot storage: handle memory with registered read and per-slot
// filled flags.
// ----------------------------------------------------------------------------
module srq_slot_store (
  input  logic                                   clk,
  input  logic                                   rst,
  input  srq_pkg::store_ctl_t                    ctl,
  input  logic [srq_pkg::SLOT_W-1:0]             rd_slot,
  output logic [srq_pkg::HANDLE_W-1:0]           rd_handle,
  output logic [srq_pkg::WINDOW_DEPTH-1:0]       filled
);

  logic [srq_pkg::HANDLE_W-1:0] mem [srq_pkg::WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_slot] <= ctl.wr_handle;
    end
    rd_handle <= mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else begin
      if (ctl.wr_en) begin
        filled[ctl.wr_slot] <= 1'b1;
      end
      if (ctl.clr_en) begin
        filled[ctl.clr_slot] <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/sequence_reorder_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_queue_unit
// Reorder queue for numbered segments over a circular slot window.
//
//   channel  | handshake          | word
//   ---------+--------------------+---------------------------------------
//   in       | in_valid/in_stall  | mode, seq_no, handle
//   out      | out_valid/out_stall| status, out_seq_no, out_handle,
//            |                    | ready_count, grow_request
//   cfg      | cfg_we             | cfg_index, cfg_data
//
// A take word passes S_TAKE and S_FINISH; an arrival passes S_CHECK, then
// the single-step release scan (S_SCAN) over the filled flags, which
// releases up to WINDOW_DEPTH segments, then S_FINISH.
// One word at a time; in_stall is high from accept until the result is
// handed to the output register, which then waits for out_stall to drop.
// A result word still held there keeps the next result waiting in S_FINISH.
// Synchronous reset empties the window; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sequence_reorder_queue_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic [srq_pkg::SEQ_W-1:0]            seq_no,
  input  logic [srq_pkg::HANDLE_W-1:0]         handle,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           status,
  output logic [srq_pkg::SEQ_W-1:0]            out_seq_no,
  output logic [srq_pkg::HANDLE_W-1:0]         out_handle,
  output logic [srq_pkg::CNT_W-1:0]            ready_count,
  output logic                                 grow_request,
  input  logic                                 cfg_we,
  input  logic [srq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srq_pkg::CFG_W-1:0]            cfg_data
);

  localparam int SW = srq_pkg::SLOT_W;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s == SW'(srq_pkg::WINDOW_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  srq_pkg::state_t state, state_next;

  logic [srq_pkg::SEQ_W-1:0]    item_seq;
  logic [srq_pkg::HANDLE_W-1:0] item_handle;
  logic [srq_pkg::SEQ_W-1:0]    head_number;
  logic [srq_pkg::SEQ_W-1:0]    expected_number;
  logic [SW-1:0]                head_slot;
  logic [SW-1:0]                exp_slot;
  logic [srq_pkg::CNT_W-1:0]    ready_cnt;
  logic                         grow_latched;
  logic                         grow_enable;
  logic [srq_pkg::CFG_W-1:0]    grow_threshold;

  srq_pkg::status_t             res_status;
  logic [srq_pkg::SEQ_W-1:0]    res_seq;
  logic [srq_pkg::HANDLE_W-1:0] res_handle;
  logic                         res_grow;

  srq_pkg::store_ctl_t                 ctl;
  logic [srq_pkg::HANDLE_W-1:0]        rd_handle;
  logic [srq_pkg::WINDOW_DEPTH-1:0]    filled;

  logic [srq_pkg::SEQ_W-1:0] behind;
  logic [srq_pkg::SEQ_W-1:0] offset;
  logic [SW:0]               slot_sum;
  logic [SW-1:0]             chk_slot;
  logic                      is_stale;
  logic                      is_beyond;
  logic                      is_dup;
  logic                      scan_go;
  logic                      out_free;
  logic                      in_accept;

  srq_slot_store u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rd_slot   (head_slot),
    .rd_handle (rd_handle),
    .filled    (filled)
  );

  // arrival checks
  always_comb begin
    behind    = item_seq - expected_number;
    offset    = item_seq - head_number;
    slot_sum  = {1'b0, head_slot} + {1'b0, offset[SW-1:0]};
    if (slot_sum >= (SW+1)'(srq_pkg::WINDOW_DEPTH)) begin
      chk_slot = SW'(slot_sum - (SW+1)'(srq_pkg::WINDOW_DEPTH));
    end else begin
      chk_slot = slot_sum[SW-1:0];
    end
    is_stale  = behind[srq_pkg::SEQ_W-1];
    is_beyond = offset >= srq_pkg::SEQ_W'(srq_pkg::WINDOW_DEPTH);
    is_dup    = filled[chk_slot];
    scan_go   = (ready_cnt < srq_pkg::CNT_W'(srq_pkg::WINDOW_DEPTH)) && filled[exp_slot];
  end

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != srq_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl.wr_en     = 1'b0;
    ctl.wr_slot   = chk_slot;
    ctl.wr_handle = item_handle;
    ctl.clr_en    = 1'b0;
    ctl.clr_slot  = head_slot;
    unique case (state)
      srq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = mode ? srq_pkg::S_TAKE : srq_pkg::S_CHECK;
        end
      end
      srq_pkg::S_CHECK: begin
        ctl.wr_en  = !is_stale && !is_beyond && !is_dup;
        state_next = srq_pkg::S_SCAN;
      end
      srq_pkg::S_SCAN: begin
        if (!scan_go) begin
          state_next = srq_pkg::S_FINISH;
        end
      end
      srq_pkg::S_TAKE: begin
        ctl.clr_en = (ready_cnt != '0);
        state_next = srq_pkg::S_FINISH;
      end
      srq_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = srq_pkg::S_IDLE;
        end
      end
      default: state_next = srq_pkg::S_IDLE;
    endcase
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      grow_enable    <= 1'b0;
      grow_threshold <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srq_pkg::CFG_GROW_ENABLE:    grow_enable    <= cfg_data[0];
        srq_pkg::CFG_GROW_THRESHOLD: grow_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // window pointers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      head_number     <= '0;
      expected_number <= '0;
      head_slot       <= '0;
      exp_slot        <= '0;
      ready_cnt       <= '0;
      grow_latched    <= 1'b0;
    end else begin
      unique case (state)
        srq_pkg::S_IDLE: begin
          if (in_accept) begin
            item_seq    <= seq_no;
            item_handle <= handle;
          end
        end
        srq_pkg::S_CHECK: begin
          res_seq    <= item_seq;
          res_handle <= '0;
          res_grow   <= 1'b0;
          if (is_stale) begin
            res_status <= srq_pkg::STAT_STALE;
          end else if (is_beyond) begin
            res_status <= srq_pkg::STAT_BEYOND;
          end else if (is_dup) begin
            res_status <= srq_pkg::STAT_STALE;
          end else begin
            res_status <= srq_pkg::STAT_OK;
          end
        end
        srq_pkg::S_SCAN: begin
          if (scan_go) begin
            expected_number <= expected_number + 1'b1;
            exp_slot        <= slot_inc(exp_slot);
            ready_cnt       <= ready_cnt + 1'b1;
          end else if (grow_enable && !grow_latched && (ready_cnt > grow_threshold)) begin
            grow_latched <= 1'b1;
            res_grow     <= 1'b1;
          end
        end
        srq_pkg::S_TAKE: begin
          res_grow <= 1'b0;
          if (ready_cnt != '0) begin
            res_status  <= srq_pkg::STAT_OK;
            res_seq     <= head_number;
            res_handle  <= rd_handle;
            head_number <= head_number + 1'b1;
            head_slot   <= slot_inc(head_slot);
            ready_cnt   <= ready_cnt - 1'b1;
          end else begin
            res_status <= srq_pkg::STAT_EMPTY;
            res_seq    <= '0;
            res_handle <= '0;
          end
        end
        srq_pkg::S_FINISH: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == srq_pkg::S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == srq_pkg::S_FINISH && out_free) begin
      status       <= res_status;
      out_seq_no   <= res_seq;
      out_handle   <= res_handle;
      ready_count  <= ready_cnt;
      grow_request <= res_grow;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sequence_reorder_queue_unit. A scoreboard keeps its
// own copy of the slot window and the ready region, predicts every result
// word from the accepted input words and checks each output word in order.
// A short directed run covers empty takes, stale, duplicate and beyond-window
// numbers. Random phases with different take rates and grow settings follow.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_ARRIVE    = 1'b0;
  localparam logic MODE_TAKE      = 1'b1;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   PHASE_WORDS    = 305;
  localparam int   NUM_PHASES     = 6;

  typedef struct {
    srq_pkg::status_t             st_code;
    logic [srq_pkg::SEQ_W-1:0]    seq;
    logic [srq_pkg::HANDLE_W-1:0] hnd;
    logic [srq_pkg::CNT_W-1:0]    cnt;
    logic                         grow;
  } reorder_result_t;

  class reorder_scoreboard;
    bit                         slot_busy[srq_pkg::WINDOW_DEPTH];
    bit [srq_pkg::HANDLE_W-1:0] slot_hnd[srq_pkg::WINDOW_DEPTH];
    bit [srq_pkg::SEQ_W-1:0]    head_no;
    bit [srq_pkg::SEQ_W-1:0]    next_no;
    int unsigned                head_idx;
    bit                         grow_seen;
    bit                         grow_on;
    bit [srq_pkg::CNT_W-1:0]    grow_limit;
    reorder_result_t            due_q[$];
    int unsigned                errors;

    function void set_growth(bit en, bit [srq_pkg::CNT_W-1:0] thr);
      grow_on    = en;
      grow_limit = thr;
    endfunction

    function bit [srq_pkg::SEQ_W-1:0] ready();
      return next_no - head_no;
    endfunction

    function int unsigned slot_for(bit [srq_pkg::SEQ_W-1:0] n);
      bit [srq_pkg::SEQ_W-1:0] off;
      off = n - head_no;
      return (head_idx + off) % srq_pkg::WINDOW_DEPTH;
    endfunction

    function void note_word(logic m, logic [srq_pkg::SEQ_W-1:0] s,
                            logic [srq_pkg::HANDLE_W-1:0] h);
      reorder_result_t          r;
      bit [srq_pkg::SEQ_W-1:0]  dist_v;
      int unsigned              idx;
      r = '{srq_pkg::STAT_OK, '0, '0, '0, 1'b0};
      if (m == MODE_TAKE) begin
        if (next_no != head_no) begin
          r.seq = head_no;
          r.hnd = slot_hnd[head_idx];
          slot_busy[head_idx] = 1'b0;
          head_no++;
          head_idx = (head_idx + 1) % srq_pkg::WINDOW_DEPTH;
        end else begin
          r.st_code = srq_pkg::STAT_EMPTY;
        end
      end else begin
        r.seq = s;
        dist_v = s - head_no;
        if (s - next_no >= 32'h8000_0000) begin
          r.st_code = srq_pkg::STAT_STALE;
        end else if (dist_v >= srq_pkg::WINDOW_DEPTH) begin
          r.st_code = srq_pkg::STAT_BEYOND;
        end else begin
          idx = slot_for(s);
          if (slot_busy[idx]) begin
            r.st_code = srq_pkg::STAT_STALE;
          end else begin
            slot_busy[idx] = 1'b1;
            slot_hnd[idx]  = h;
            while (ready() < srq_pkg::WINDOW_DEPTH && slot_busy[slot_for(next_no)])
              next_no++;
          end
        end
        if (grow_on && !grow_seen && ready() > grow_limit) begin
          grow_seen = 1'b1;
          r.grow    = 1'b1;
        end
      end
      r.cnt = srq_pkg::CNT_W'(ready());
      due_q.insert(due_q.size(), r);
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task check_word(srq_pkg::status_t st, logic [srq_pkg::SEQ_W-1:0] sq,
                    logic [srq_pkg::HANDLE_W-1:0] h,
                    logic [srq_pkg::CNT_W-1:0] c, logic g);
      reorder_result_t want;
      if (due_q.size() == 0) begin
        report("result word with nothing outstanding");
        return;
      end
      want = due_q[0];
      due_q.delete(0);
      if (st !== want.st_code)
        report($sformatf("status %0d, want %0d", st, want.st_code));
      if (sq !== want.seq)
        report($sformatf("out_seq_no %h, want %h", sq, want.seq));
      if (h !== want.hnd)
        report($sformatf("out_handle %h, want %h", h, want.hnd));
      if (c !== want.cnt)
        report($sformatf("ready_count %0d, want %0d", c, want.cnt));
      if (g !== want.grow)
        report($sformatf("grow_request %b, want %b", g, want.grow));
    endtask
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                mode = MODE_ARRIVE;
  logic [srq_pkg::SEQ_W-1:0]           seq_no = '0;
  logic [srq_pkg::HANDLE_W-1:0]        handle = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [1:0]                          status;
  logic [srq_pkg::SEQ_W-1:0]           out_seq_no;
  logic [srq_pkg::HANDLE_W-1:0]        out_handle;
  logic [srq_pkg::CNT_W-1:0]           ready_count;
  logic                                grow_request;
  logic                                cfg_we = 1'b0;
  logic [srq_pkg::CFG_IDX_W-1:0]       cfg_index = srq_pkg::CFG_GROW_ENABLE;
  logic [srq_pkg::CFG_W-1:0]           cfg_data = '0;

  reorder_scoreboard sb;
  bit                steady = 1'b0;
  int unsigned       idle_cycles = 0;

  bit          phase_en[NUM_PHASES]   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  int unsigned phase_thr[NUM_PHASES]  = '{0, 64, 20, 45, 0, 64};
  int unsigned phase_take[NUM_PHASES] = '{15, 10, 60, 20, 50, 35};

  sequence_reorder_queue_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .seq_no       (seq_no),
    .handle       (handle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_seq_no   (out_seq_no),
    .out_handle   (out_handle),
    .ready_count  (ready_count),
    .grow_request (grow_request),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 34);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word(srq_pkg::status_t'(status), out_seq_no, out_handle, ready_count,
                    grow_request);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // word stays on the bus after acceptance; caller lowers valid when done
  task automatic send_word(input logic m, input logic [srq_pkg::SEQ_W-1:0] s,
                           input logic [srq_pkg::HANDLE_W-1:0] h);
    while (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    seq_no   <= s;
    handle   <= h;
    do @(posedge clk); while (in_stall);
    sb.note_word(m, s, h);
  endtask

  task automatic random_word(input int unsigned take_pct);
    bit [srq_pkg::SEQ_W-1:0] rdy;
    bit [srq_pkg::SEQ_W-1:0] s;
    int unsigned             span;
    int unsigned             pick;
    rdy  = sb.ready();
    span = (rdy < srq_pkg::WINDOW_DEPTH) ? srq_pkg::WINDOW_DEPTH - 1 - rdy : 0;
    pick = $urandom_range(99);
    if ($urandom_range(99) < take_pct) begin
      send_word(MODE_TAKE, $urandom, srq_pkg::HANDLE_W'($urandom));
      return;
    end
    if (pick < 70)      s = sb.next_no + $urandom_range(0, (span < 7) ? span : 7);
    else if (pick < 80) s = sb.next_no + $urandom_range(0, span);
    else if (pick < 88) s = sb.next_no - $urandom_range(1, rdy + 2);
    else if (pick < 92) s = sb.next_no - $urandom_range(1, 32'h8000_0000);
    else if (pick < 96) s = sb.head_no + srq_pkg::WINDOW_DEPTH + $urandom_range(0, 300);
    else                s = $urandom;
    send_word(MODE_ARRIVE, s, srq_pkg::HANDLE_W'($urandom));
  endtask

  task automatic drain();
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_growth(input bit en, input bit [srq_pkg::CNT_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= srq_pkg::CFG_GROW_ENABLE;
    cfg_data  <= srq_pkg::CFG_W'(en);
    @(posedge clk);
    cfg_index <= srq_pkg::CFG_GROW_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_growth(en, thr);
  endtask

  initial begin
    sb = new;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(MODE_TAKE,   32'h0000_0000, 16'h0000);
    send_word(MODE_ARRIVE, 32'h0000_0001, 16'hFFFF);
    send_word(MODE_ARRIVE, 32'h0000_0001, 16'h1234);
    send_word(MODE_ARRIVE, 32'h0000_0000, 16'h0000);
    send_word(MODE_ARRIVE, 32'h0000_0000, 16'hAAAA);
    send_word(MODE_ARRIVE, 32'h0000_0040, 16'h5555);
    send_word(MODE_ARRIVE, 32'h0000_003F, 16'h5A5A);
    send_word(MODE_ARRIVE, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_ARRIVE, 32'h8000_0001, 16'h0001);
    send_word(MODE_ARRIVE, 32'h7FFF_FFFF, 16'h8000);
    send_word(MODE_ARRIVE, 32'h0000_003F, 16'h0F0F);
    send_word(MODE_TAKE,   32'h0000_0000, 16'h0000);
    send_word(MODE_TAKE,   32'h0000_0000, 16'h0000);
    send_word(MODE_TAKE,   32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_ARRIVE, 32'h0000_0040, 16'hC3C3);
    send_word(MODE_ARRIVE, 32'h0000_0042, 16'h3C3C);
    send_word(MODE_ARRIVE, 32'h0000_0002, 16'h7FFF);
    send_word(MODE_TAKE,   32'h0000_0000, 16'h0000);
    in_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_growth(phase_en[p], srq_pkg::CNT_W'(phase_thr[p]));
      steady = (p == NUM_PHASES - 1);
      for (int n = 0; n < PHASE_WORDS; n++) random_word(phase_take[p]);
      in_valid <= 1'b0;
    end

    drain();
    steady = 1'b0;
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/srq_pkg.sv
hw/rtl/srq_slot_store.sv
hw/rtl/sequence_reorder_queue_unit.sv
test/tb_top.sv
